[rtl/completion_prefix_tracker_defines.svh]
// ---------------------------------------------------------------------------
// Completion prefix tracker assertion macros
// Shared concurrent assertion forms, clocked by i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef COMPLETION_PREFIX_TRACKER_DEFINES_SVH
`define COMPLETION_PREFIX_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPT_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cpt_pkg.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker package
// Types, codes and constants shared by the tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

    localparam int MAX_SLOTS  = 32;
    localparam int WINDOW     = 64;
    localparam int SLOT_W     = 5;
    localparam int WIN_W      = 6;
    localparam int QD_W       = 6;
    localparam int UNIT_W     = 48;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 2;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ISSUE = 2'd1;
    localparam logic [1:0] REQ_CMPL  = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    localparam logic [3:0] K_GRANT  = 4'd0;
    localparam logic [3:0] K_REFUSE = 4'd1;
    localparam logic [3:0] K_SUBMIT = 4'd2;
    localparam logic [3:0] K_CKPT   = 4'd3;
    localparam logic [3:0] K_FLUSH  = 4'd4;
    localparam logic [3:0] K_ACK    = 4'd5;
    localparam logic [3:0] K_DONE   = 4'd6;
    localparam logic [3:0] K_ERROR  = 4'd7;
    localparam logic [3:0] K_STOP   = 4'd8;

    localparam logic [IDX_W-1:0] CFG_QUEUE_DEPTH = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CHUNK       = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CHECKPOINT  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_PLP         = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [UNIT_W-1:0] start_unit;
        logic [UNIT_W-1:0] unit_count;
        logic [SLOT_W-1:0] slot;
        logic              success;
    } t_item;

    typedef struct packed {
        logic [3:0]        kind;
        logic [SLOT_W-1:0] slot_res;
        logic [UNIT_W-1:0] unit_offset;
        logic [UNIT_W-1:0] mark_value;
        logic              last;
    } t_result;

    function automatic t_result mk_res(input logic [3:0] kind, input logic [SLOT_W-1:0] slot,
                                       input logic [UNIT_W-1:0] off,
                                       input logic [UNIT_W-1:0] mark);
        t_result r;
        r.kind        = kind;
        r.slot_res    = slot;
        r.unit_offset = off;
        r.mark_value  = mark;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/completion_prefix_tracker.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker
// Tracks out-of-order write completions for one phase of units and reports
// grants, submitted marks, durable marks and phase completion.
//
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tdata requests, tuser request type
// m         out  o_m_tvalid/i_m_tready  tdata results, tuser kind, tlast
// cfg       in   i_cfg_valid/o_cfg_ready  register index and write data
//
// A successful completion advances the prefix one unit at a time, up to the
// 64-entry window, and a volatile flush also runs the serial remainder unit.
// Reset is synchronous and needs no clearing pass. A stalled result holds in
// the output register while the request queue keeps filling.
// ---------------------------------------------------------------------------
`default_nettype none

module completion_prefix_tracker
    import cpt_pkg::*;
#(
    parameter int FRONT_DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // start_unit[47:0], unit_count[95:48], slot[100:96], success[101], zero fill
    input  wire logic [103:0]     i_s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // slot_res[4:0], unit_offset[52:5], mark_value[100:53], zero fill
    output logic [103:0]          o_m_tdata,
    // kind[3:0]
    output logic [3:0]            o_m_tuser,
    output logic                  o_m_tlast,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic    item_valid;
    t_item   item;
    logic    pop;
    t_result result;

    assign o_cfg_ready = 1'b1;

    cpt_front #(
        .DEPTH (FRONT_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    cpt_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_result     (result)
    );

    assign o_m_tdata = {3'b000, result.mark_value, result.unit_offset, result.slot_res};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = result.last;

endmodule

`default_nettype wire

[rtl/cpt_front.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker front end
// Accepts request transactions, decodes them and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

`include "completion_prefix_tracker_defines.svh"

module cpt_front
    import cpt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [103:0] i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_item_valid,
    output t_item             o_item,
    input  wire logic         i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_q [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               push;
    logic               pop;
    t_item              dec;

    always_comb begin
        dec.req_type   = i_s_tuser;
        dec.start_unit = i_s_tdata[47:0];
        dec.unit_count = i_s_tdata[95:48];
        dec.slot       = i_s_tdata[100:96];
        dec.success    = i_s_tdata[101];
    end

    assign o_s_tready   = (r_cnt != CNT_W'(DEPTH));
    assign push         = i_s_tvalid && o_s_tready;
    assign pop          = i_pop && (r_cnt != '0);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

    `CPT_ASSERT(a_front_cnt_bound, 1'b1, r_cnt <= CNT_W'(DEPTH), "front queue overfilled")
    `CPT_ASSERT_NEXT(a_front_push_only, push && !pop, r_cnt == $past(r_cnt) + 1'b1,
        "front queue lost a transaction")

endmodule

`default_nettype wire

[rtl/cpt_divrem.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker remainder unit
// Restoring division, one quotient bit per cycle, giving the remainder only.
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_divrem
    import cpt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [UNIT_W-1:0] i_dividend,
    input  wire logic [CFG_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [CFG_W-1:0]       o_rem
);

    localparam int CNT_W = $clog2(UNIT_W + 1);

    logic              r_busy, n_busy;
    logic              r_fin, n_fin;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [UNIT_W-1:0] r_dvd, n_dvd;
    logic [CFG_W-1:0]  r_dvs, n_dvs;
    logic [CFG_W-1:0]  r_rem, n_rem;
    logic [CFG_W:0]    trial;

    assign trial  = {r_rem, r_dvd[UNIT_W-1]};
    assign o_done = r_fin;
    assign o_rem  = r_rem;

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(UNIT_W);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = (trial >= {1'b0, r_dvs}) ? CFG_W'(trial - {1'b0, r_dvs}) : trial[CFG_W-1:0];
            n_dvd = {r_dvd[UNIT_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

[rtl/cpt_exec.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker back end
// Executes queued requests against the slot, window and mark state and
// delivers result transactions through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "completion_prefix_tracker_defines.svh"

module cpt_exec
    import cpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_item_valid,
    input  wire t_item            i_item,
    output logic                  o_pop,
    input  wire logic             i_cfg_valid,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output t_result               o_result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_GRANT = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_POST  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FLUSH = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [QD_W-1:0]   r_qd_cfg;
    logic [CFG_W-1:0]  r_chunk, r_ckpt;
    logic              r_plp;

    logic [QD_W-1:0]   r_phase_qd, n_phase_qd;
    logic [QD_W-1:0]   r_free_top, n_free_top;
    logic [QD_W-1:0]   r_inflight, n_inflight;
    logic [SLOT_W-1:0] r_stack [MAX_SLOTS];
    logic [SLOT_W-1:0] n_stack [MAX_SLOTS];
    logic [UNIT_W-1:0] r_slot_off [MAX_SLOTS];
    logic [UNIT_W-1:0] n_slot_off [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_busy, n_busy;
    logic [WINDOW-1:0] r_done, n_done;
    logic [UNIT_W-1:0] r_next, n_next, r_prefix, n_prefix, r_claimed, n_claimed;
    logic [UNIT_W-1:0] r_lpersist, n_lpersist, r_lflush, n_lflush;
    logic [UNIT_W-1:0] r_base, n_base, r_len, n_len;
    logic              r_claim_flag, n_claim_flag;
    t_item             r_item, n_item;
    t_result           r_res [2];
    t_result           n_res [2];
    logic [1:0]        r_nres, n_nres;
    logic              r_ridx, n_ridx;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [CFG_W-1:0]  chunk_eff, ckpt_eff;
    logic [QD_W-1:0]   qd_eff;
    logic              active;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [CFG_W-1:0]  div_rem;
    logic [UNIT_W-1:0] flush_diff;

    assign chunk_eff  = (r_chunk == '0) ? CFG_W'(1) : r_chunk;
    assign ckpt_eff   = (r_ckpt == '0) ? CFG_W'(1) : r_ckpt;
    assign qd_eff     = (r_qd_cfg == '0) ? QD_W'(1)
                      : ((r_qd_cfg > QD_W'(MAX_SLOTS)) ? QD_W'(MAX_SLOTS) : r_qd_cfg);
    assign active     = r_prefix < r_len;
    assign out_free   = !r_out_valid || i_m_tready;
    assign flush_diff = r_prefix - r_lflush;
    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

    cpt_divrem u_divrem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (flush_diff),
        .i_divisor  (chunk_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        logic [UNIT_W:0]   claim_sum;
        logic [SLOT_W-1:0] s;
        logic [UNIT_W-1:0] off;
        t_result           res;
        logic              do_push;

        n_state      = r_state;
        n_phase_qd   = r_phase_qd;
        n_free_top   = r_free_top;
        n_inflight   = r_inflight;
        n_stack      = r_stack;
        n_slot_off   = r_slot_off;
        n_busy       = r_busy;
        n_done       = r_done;
        n_next       = r_next;
        n_prefix     = r_prefix;
        n_claimed    = r_claimed;
        n_lpersist   = r_lpersist;
        n_lflush     = r_lflush;
        n_base       = r_base;
        n_len        = r_len;
        n_claim_flag = r_claim_flag;
        n_item       = r_item;
        n_res        = r_res;
        n_nres       = r_nres;
        n_ridx       = r_ridx;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_m_tready;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        claim_sum    = '0;
        s            = '0;
        off          = '0;
        res          = mk_res(K_ACK, '0, r_prefix, '0);
        do_push      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_nres  = '0;
                    n_ridx  = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.req_type)
                    REQ_START: begin
                        n_done     = '0;
                        n_busy     = '0;
                        for (int i = 0; i < MAX_SLOTS; i++) begin
                            n_stack[i] = SLOT_W'(i);
                        end
                        n_phase_qd = qd_eff;
                        n_free_top = qd_eff;
                        n_inflight = '0;
                        n_next     = '0;
                        n_prefix   = '0;
                        n_claimed  = '0;
                        n_lpersist = '0;
                        n_lflush   = '0;
                        n_base     = r_item.start_unit;
                        n_len      = r_item.unit_count;
                        res        = mk_res((r_item.unit_count == '0) ? K_DONE : K_ACK, '0, '0,
                                            r_item.start_unit);
                        do_push    = 1'b1;
                        n_state    = S_EMIT;
                    end
                    REQ_ISSUE: begin
                        if (!active) begin
                            res     = mk_res(K_REFUSE, '0, r_prefix, '0);
                            do_push = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            n_claim_flag = 1'b0;
                            if (r_next >= r_claimed && r_claimed < r_len) begin
                                claim_sum    = {1'b0, r_claimed} + (UNIT_W + 1)'(chunk_eff);
                                n_claimed    = (claim_sum > {1'b0, r_len}) ? r_len
                                                                           : claim_sum[UNIT_W-1:0];
                                n_claim_flag = 1'b1;
                            end
                            n_state = S_GRANT;
                        end
                    end
                    REQ_CMPL: begin
                        s = r_item.slot;
                        if (!r_busy[s]) begin
                            res     = mk_res(K_ERROR, '0, r_prefix, '0);
                            do_push = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            off       = r_slot_off[s];
                            n_busy[s] = 1'b0;
                            if (r_free_top < QD_W'(MAX_SLOTS)) begin
                                n_stack[r_free_top[SLOT_W-1:0]] = s;
                                n_free_top = r_free_top + 1'b1;
                            end
                            if (r_inflight != '0) begin
                                n_inflight = r_inflight - 1'b1;
                            end
                            if (!active) begin
                                res     = mk_res(K_ACK, '0, r_prefix, '0);
                                do_push = 1'b1;
                                n_state = S_EMIT;
                            end else if (!r_item.success) begin
                                n_len   = r_prefix;
                                res     = mk_res(K_ERROR, '0, r_prefix, '0);
                                do_push = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                n_done[off[WIN_W-1:0]] = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                    end
                    REQ_STOP: begin
                        res     = mk_res(K_STOP, '0, r_prefix,
                                         r_base + (r_plp ? r_lpersist : r_lflush));
                        do_push = 1'b1;
                        n_len   = r_prefix;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_GRANT: begin
                if (r_claim_flag) begin
                    n_res[0] = mk_res(K_SUBMIT, '0, r_prefix, r_base + r_claimed);
                end
                if (r_inflight < r_phase_qd && r_free_top != '0 && r_next < r_claimed &&
                    (r_next - r_prefix) < UNIT_W'(WINDOW)) begin
                    s             = r_stack[SLOT_W'(r_free_top - 1'b1)];
                    n_slot_off[s] = r_next;
                    n_busy[s]     = 1'b1;
                    n_inflight    = r_inflight + 1'b1;
                    n_free_top    = r_free_top - 1'b1;
                    n_next        = r_next + 1'b1;
                    res           = mk_res(K_GRANT, s, r_next, r_base + r_next);
                end else begin
                    res = mk_res(K_REFUSE, '0, r_prefix, '0);
                end
                n_res[r_claim_flag] = res;
                n_nres  = r_claim_flag ? 2'd2 : 2'd1;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (active && r_done[r_prefix[WIN_W-1:0]]) begin
                    n_done[r_prefix[WIN_W-1:0]] = 1'b0;
                    n_prefix = r_prefix + 1'b1;
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_plp) begin
                    if ((r_prefix - r_lpersist) >= UNIT_W'(ckpt_eff)) begin
                        n_lpersist = r_prefix;
                        res        = mk_res(K_CKPT, '0, r_prefix, r_base + r_prefix);
                        do_push    = 1'b1;
                    end
                    n_state = S_FIN;
                end else if (flush_diff >= UNIT_W'(chunk_eff)) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_lflush = r_prefix - UNIT_W'(div_rem);
                    n_state  = S_FLUSH;
                end
            end
            S_FLUSH: begin
                res     = mk_res(K_FLUSH, '0, r_prefix, r_base + r_lflush);
                do_push = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!active) begin
                    res     = mk_res(K_DONE, '0, r_prefix, r_base + r_len);
                    do_push = 1'b1;
                end else if (r_nres == '0) begin
                    res     = mk_res(K_ACK, '0, r_prefix, '0);
                    do_push = 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res[r_ridx];
                    n_out.last  = ({1'b0, r_ridx} == r_nres - 1'b1);
                    n_out_valid = 1'b1;
                    if (n_out.last) begin
                        n_ridx  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_ridx = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_push) begin
            n_res[r_nres[0]] = res;
            n_nres           = r_nres + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_qd_cfg     <= QD_W'(32);
            r_chunk      <= CFG_W'(256);
            r_ckpt       <= CFG_W'(16);
            r_plp        <= 1'b0;
            r_phase_qd   <= QD_W'(MAX_SLOTS);
            r_free_top   <= QD_W'(MAX_SLOTS);
            r_inflight   <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_stack[i] <= SLOT_W'(i);
            end
            r_busy       <= '0;
            r_done       <= '0;
            r_next       <= '0;
            r_prefix     <= '0;
            r_claimed    <= '0;
            r_lpersist   <= '0;
            r_lflush     <= '0;
            r_base       <= '0;
            r_len        <= '0;
            r_claim_flag <= 1'b0;
            r_nres       <= '0;
            r_ridx       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_QUEUE_DEPTH: r_qd_cfg <= i_cfg_data[QD_W-1:0];
                    CFG_CHUNK:       r_chunk  <= i_cfg_data;
                    CFG_CHECKPOINT:  r_ckpt   <= i_cfg_data;
                    CFG_PLP:         r_plp    <= i_cfg_data[0];
                    default:         r_plp    <= r_plp;
                endcase
            end
            r_phase_qd   <= n_phase_qd;
            r_free_top   <= n_free_top;
            r_inflight   <= n_inflight;
            r_stack      <= n_stack;
            r_busy       <= n_busy;
            r_done       <= n_done;
            r_next       <= n_next;
            r_prefix     <= n_prefix;
            r_claimed    <= n_claimed;
            r_lpersist   <= n_lpersist;
            r_lflush     <= n_lflush;
            r_base       <= n_base;
            r_len        <= n_len;
            r_claim_flag <= n_claim_flag;
            r_nres       <= n_nres;
            r_ridx       <= n_ridx;
            r_out_valid  <= n_out_valid;
        end
        r_slot_off <= n_slot_off;
        r_item     <= n_item;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    `CPT_ASSERT(a_slot_balance, 1'b1,
        ({1'b0, r_free_top} + {1'b0, r_inflight}) == {1'b0, r_phase_qd},
        "free slots and writes in flight do not add up to the queue depth")
    `CPT_ASSERT(a_busy_count, 1'b1, QD_W'($countones(r_busy)) == r_inflight,
        "busy slot count differs from the in-flight count")
    `CPT_ASSERT(a_prefix_order, 1'b1, r_prefix <= r_next,
        "completed prefix passed the next unit to grant")
    `CPT_ASSERT_NEXT(a_emit_hold, r_out_valid && !i_m_tready, r_out_valid,
        "result transaction dropped while stalled")

endmodule

`default_nettype wire

[tb/sv/tb_completion_prefix_tracker.sv]
// ---------------------------------------------------------------------------
// Completion prefix tracker testbench
// Drives start, issue, completion and stop requests through the request
// stream, with register writes between phases, and checks every result
// against a cycle-free behavioral predictor of the tracker. Both stream sides
// idle at random, with some stretches run at full rate.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_completion_prefix_tracker;
    import cpt_pkg::*;

    localparam int SETTLE_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [UNIT_W-1:0] M48 = {UNIT_W{1'b1}};

    typedef struct {
        bit               is_cfg;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] val;
        t_item            it;
        bit               pick_busy;
        bit               full_rate;
    } t_op;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [103:0]       i_s_tdata = '0;
    logic [1:0]         i_s_tuser = '0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [103:0]       o_m_tdata;
    logic [3:0]         o_m_tuser;
    logic               o_m_tlast;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    completion_prefix_tracker DUT (.*);

    always #5 i_clk = ~i_clk;

    // Tracker state as predicted.
    logic [5:0]        reg_qd;
    logic [31:0]       reg_chunk, reg_ckpt;
    bit                reg_plp;
    bit                done_map [64];
    longint unsigned   slot_unit [MAX_SLOTS];
    bit                slot_busy [MAX_SLOTS];
    int unsigned       free_stack [MAX_SLOTS];
    int unsigned       free_top;
    longint unsigned   next_unit, prefix, claimed, in_flight;
    longint unsigned   persist_mark, flush_mark, base_unit, phase_len, lat_qd, lat_win;

    t_op     pending_ops [$];
    t_result results_due [$];
    t_item   cur_item;
    int      mismatches = 0;
    bit      quiet = 1'b0;

    function automatic void clear_tracking();
        for (int i = 0; i < 64; i++) done_map[i] = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_unit[i] = 0;
            slot_busy[i] = 1'b0;
            free_stack[i] = i;
        end
        lat_qd = (reg_qd == 0) ? 1 : ((reg_qd > MAX_SLOTS) ? MAX_SLOTS : reg_qd);
        lat_win = (2 * lat_qd > WINDOW) ? 2 * lat_qd : WINDOW;
        free_top = lat_qd;
        next_unit = 0; prefix = 0; claimed = 0; in_flight = 0;
        persist_mark = 0; flush_mark = 0;
    endfunction

    function automatic void expect_result(logic [3:0] kind, logic [SLOT_W-1:0] slot,
                                          longint unsigned off, longint unsigned mark);
        t_result r;
        r.kind = kind;
        r.slot_res = slot;
        r.unit_offset = off[UNIT_W-1:0];
        r.mark_value = mark[UNIT_W-1:0] & M48;
        r.last = 1'b0;
        results_due.push_back(r);
    endfunction

    function automatic void track_request(t_item it);
        longint unsigned chunk, ckpt, off;
        int unsigned     s;
        bit              active;
        int              first;
        chunk = (reg_chunk == 0) ? 1 : reg_chunk;
        ckpt = (reg_ckpt == 0) ? 1 : reg_ckpt;
        active = prefix < phase_len;
        first = results_due.size();
        case (it.req_type)
            REQ_START: begin
                clear_tracking();
                base_unit = it.start_unit;
                phase_len = it.unit_count;
                expect_result(phase_len == 0 ? K_DONE : K_ACK, 0, 0, base_unit);
            end
            REQ_ISSUE: begin
                if (!active) begin
                    expect_result(K_REFUSE, 0, prefix, 0);
                end else begin
                    if (next_unit >= claimed && claimed < phase_len) begin
                        claimed += chunk;
                        if (claimed > phase_len) claimed = phase_len;
                        expect_result(K_SUBMIT, 0, prefix, base_unit + claimed);
                    end
                    if (in_flight < lat_qd && free_top > 0 && next_unit < claimed &&
                        next_unit - prefix < lat_win) begin
                        free_top--;
                        s = free_stack[free_top] % MAX_SLOTS;
                        slot_unit[s] = next_unit;
                        slot_busy[s] = 1'b1;
                        in_flight++;
                        expect_result(K_GRANT, SLOT_W'(s), next_unit, base_unit + next_unit);
                        next_unit++;
                    end else begin
                        expect_result(K_REFUSE, 0, prefix, 0);
                    end
                end
            end
            REQ_CMPL: begin
                s = it.slot;
                if (!slot_busy[s]) begin
                    expect_result(K_ERROR, 0, prefix, 0);
                end else begin
                    off = slot_unit[s];
                    slot_busy[s] = 1'b0;
                    if (free_top < MAX_SLOTS) begin
                        free_stack[free_top] = s;
                        free_top++;
                    end
                    if (in_flight > 0) in_flight--;
                    if (!active) begin
                        expect_result(K_ACK, 0, prefix, 0);
                    end else if (!it.success) begin
                        phase_len = prefix;
                        expect_result(K_ERROR, 0, prefix, 0);
                    end else begin
                        done_map[off % lat_win] = 1'b1;
                        while (prefix < phase_len && done_map[prefix % lat_win]) begin
                            done_map[prefix % lat_win] = 1'b0;
                            prefix++;
                        end
                        if (reg_plp) begin
                            if (prefix - persist_mark >= ckpt) begin
                                persist_mark = prefix;
                                expect_result(K_CKPT, 0, prefix, base_unit + prefix);
                            end
                        end else if (prefix - flush_mark >= chunk) begin
                            flush_mark += ((prefix - flush_mark) / chunk) * chunk;
                            expect_result(K_FLUSH, 0, prefix, base_unit + flush_mark);
                        end
                        if (prefix >= phase_len)
                            expect_result(K_DONE, 0, prefix, base_unit + phase_len);
                        if (results_due.size() == first)
                            expect_result(K_ACK, 0, prefix, 0);
                    end
                end
            end
            default: begin
                expect_result(K_STOP, 0, prefix,
                              base_unit + (reg_plp ? persist_mark : flush_mark));
                phase_len = prefix;
            end
        endcase
        results_due[$].last = 1'b1;
    endfunction

    // Driver: request stream and register writes from the pending queue.
    int unsigned s_gap = 0, settle = 0, pick;
    bit          s_vld, c_vld;
    t_op         op;
    int unsigned busy_list [$];

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            s_vld = i_s_tvalid;
            c_vld = i_cfg_valid;
            if (i_s_tvalid && o_s_tready) begin
                track_request(cur_item);
                s_vld = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUEUE_DEPTH: reg_qd = i_cfg_data[5:0];
                    CFG_CHUNK:       reg_chunk = i_cfg_data;
                    CFG_CHECKPOINT:  reg_ckpt = i_cfg_data;
                    default:         reg_plp = i_cfg_data[0];
                endcase
                c_vld = 1'b0;
            end
            if (results_due.size() != 0 || s_vld) settle = SETTLE_CYCLES;
            else if (settle > 0) settle--;
            if (!s_vld && !c_vld && pending_ops.size() != 0) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (!pending_ops[0].is_cfg) begin
                    op = pending_ops.pop_front();
                    quiet = op.full_rate;
                    cur_item = op.it;
                    if (op.pick_busy) begin
                        busy_list = {};
                        for (int i = 0; i < MAX_SLOTS; i++)
                            if (slot_busy[i]) busy_list.push_back(i);
                        if (busy_list.size() != 0) begin
                            pick = $urandom_range(0, busy_list.size() - 1);
                            cur_item.slot = SLOT_W'(busy_list[pick]);
                        end
                    end
                    i_s_tdata <= {2'b00, cur_item.success, cur_item.slot,
                                  cur_item.unit_count, cur_item.start_unit};
                    i_s_tuser <= cur_item.req_type;
                    s_vld = 1'b1;
                    s_gap = quiet ? 0 : $urandom_range(0, 5);
                end else if (settle == 0) begin
                    op = pending_ops.pop_front();
                    i_cfg_index <= op.idx;
                    i_cfg_data <= op.val;
                    c_vld = 1'b1;
                end
            end
            i_s_tvalid <= s_vld;
            i_cfg_valid <= c_vld;
        end
    end

    // Monitor: result stream checking, receiver stalls and watchdog.
    int unsigned m_stall = 0, idle_cycles = 0;
    t_result     got, want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.kind = o_m_tuser;
                got.slot_res = o_m_tdata[4:0];
                got.unit_offset = o_m_tdata[52:5];
                got.mark_value = o_m_tdata[100:53];
                got.last = o_m_tlast;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got.kind != want.kind || got.slot_res != want.slot_res ||
                        got.unit_offset != want.unit_offset ||
                        got.mark_value != want.mark_value || got.last != want.last) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        mismatches++;
                    end
                end
                m_stall = quiet ? 0 : $urandom_range(0, 5);
            end else if (m_stall > 0) begin
                m_stall--;
            end
            i_m_tready <= (m_stall == 0);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else if (results_due.size() != 0 || i_s_tvalid || i_cfg_valid)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** completion_prefix_tracker: FAILED **");
                $finish;
            end
        end
    end

    function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_op o;
        o.is_cfg = 1'b1;
        o.idx = idx;
        o.val = val;
        o.it = '0;
        o.pick_busy = 1'b0;
        o.full_rate = 1'b0;
        pending_ops.push_back(o);
    endfunction

    function automatic void add_request(logic [1:0] req, logic [UNIT_W-1:0] su,
                                        logic [UNIT_W-1:0] uc, logic [SLOT_W-1:0] slot,
                                        bit ok, bit pick, bit fast);
        t_op o;
        o.is_cfg = 1'b0;
        o.idx = '0;
        o.val = '0;
        o.it.req_type = req;
        o.it.start_unit = su;
        o.it.unit_count = uc;
        o.it.slot = slot;
        o.it.success = ok;
        o.pick_busy = pick;
        o.full_rate = fast;
        pending_ops.push_back(o);
    endfunction

    function automatic logic [UNIT_W-1:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    function automatic void random_config();
        int unsigned r;
        r = $urandom_range(0, 9);
        add_cfg(CFG_QUEUE_DEPTH, r == 0 ? 0 : (r == 1 ? 63 : $urandom_range(1, 32)));
        r = $urandom_range(0, 9);
        add_cfg(CFG_CHUNK, r == 0 ? $urandom() : (r == 1 ? 0 : $urandom_range(1, 12)));
        r = $urandom_range(0, 9);
        add_cfg(CFG_CHECKPOINT, r == 0 ? $urandom() : (r == 1 ? 0 : $urandom_range(1, 12)));
        add_cfg(CFG_PLP, $urandom_range(0, 1));
    endfunction

    int unsigned n_items, seg_len, r, cnt;
    bit          fast;

    initial begin
        reg_qd = 32; reg_chunk = 256; reg_ckpt = 16; reg_plp = 1'b0;
        clear_tracking();
        base_unit = 0; phase_len = 0;

        // Directed part: no phase, degenerate starts, extremes and a short phase.
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_CMPL, 0, 1, 5'd31, 1, 0, 0);
        add_request(REQ_STOP, 0, 1, 0, 1, 0, 0);
        add_request(REQ_START, M48, 0, 0, 1, 0, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_cfg(CFG_QUEUE_DEPTH, 1);
        add_cfg(CFG_CHUNK, 2);
        add_cfg(CFG_CHECKPOINT, 1);
        add_cfg(CFG_PLP, 1);
        add_request(REQ_START, M48 - 1, 4, 0, 1, 0, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_CMPL, 0, 1, 0, 1, 1, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_CMPL, 0, 1, 0, 1, 1, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_STOP, 0, 1, 0, 1, 0, 0);
        add_request(REQ_CMPL, 0, 1, 0, 1, 1, 0);
        add_cfg(CFG_QUEUE_DEPTH, 0);
        add_cfg(CFG_CHUNK, 32'hFFFF_FFFF);
        add_cfg(CFG_CHECKPOINT, 32'hFFFF_FFFF);
        add_cfg(CFG_PLP, 0);
        add_request(REQ_START, 0, M48, 0, 1, 0, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_CMPL, 0, 1, 0, 0, 1, 0);
        add_request(REQ_ISSUE, 0, 1, 0, 1, 0, 0);
        add_request(REQ_STOP, 0, 1, 0, 1, 0, 0);

        // Random phases: mostly well-formed issue and completion traffic.
        n_items = 0;
        while (n_items < 1050) begin
            random_config();
            fast = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            cnt = (r == 0) ? 0 : $urandom_range(1, 48);
            add_request(REQ_START, rand48(), (r == 1) ? rand48() : cnt,
                        $urandom_range(0, 31), 1, 0, fast);
            seg_len = $urandom_range(20, 80);
            for (int k = 0; k < seg_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    add_request(REQ_ISSUE, rand48(), rand48(), $urandom_range(0, 31),
                                $urandom_range(0, 1), 0, fast);
                else if (r < 92)
                    add_request(REQ_CMPL, rand48(), rand48(), $urandom_range(0, 31), 1, 1, fast);
                else if (r < 96)
                    add_request(REQ_CMPL, rand48(), rand48(), $urandom_range(0, 31),
                                $urandom_range(0, 1), $urandom_range(0, 1), fast);
                else if (r < 98)
                    add_request(REQ_STOP, rand48(), rand48(), $urandom_range(0, 31),
                                $urandom_range(0, 1), 0, fast);
                else
                    add_request(REQ_START, rand48(), $urandom_range(1, 20),
                                $urandom_range(0, 31), 1, 0, fast);
            end
            n_items += seg_len + 1;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_s_tvalid || i_cfg_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("** completion_prefix_tracker: PASSED **");
        end else begin
            $display("** completion_prefix_tracker: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
